@@ design/assert_macros.svh @@
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define ASSERT_CLK_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ design/ssd_pkg.sv @@
// Types, constants and segment tables of the seven-segment serial display driver.
package ssd_pkg;

   // Display geometry. The display has four select positions; the digit count is
   // clamped into 1..SEL_POSITIONS.
   localparam int DIGIT_COUNT   = 4;
   localparam int SEL_POSITIONS = 4;
   localparam int DIGITS_USED   = (DIGIT_COUNT < 1) ? 1 :
                                  ((DIGIT_COUNT > SEL_POSITIONS) ? SEL_POSITIONS : DIGIT_COUNT);

   // Frame index runs 0..DIGITS_USED (the trailer sits at DIGITS_USED).
   localparam int IDX_W   = $clog2(DIGITS_USED + 1);
   localparam int SEL_W   = $clog2(SEL_POSITIONS);
   localparam int GLYPH_W = 3;
   localparam int VALUE_W = 16;
   localparam int FRAME_W = 16;
   localparam int FWID_W  = 5;

   localparam logic [FWID_W-1:0] WIDTH_FULL  = 5'd16;
   localparam logic [FWID_W-1:0] WIDTH_SHORT = 5'd8;

   // Divide by ten of a 16-bit value: (x * 0xCCCD) >> 19 is exact for x below 81920.
   localparam logic [VALUE_W-1:0] DIV10_MUL   = 16'hCCCD;
   localparam int                 DIV10_SHIFT = 19;

   // Command queue between the front and back parts.
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Items that can be in flight: queue entries, the active one and one whose
   // final frame waits in the output register.
   localparam int MAX_PENDING = QUEUE_DEPTH + 2;
   localparam int PEND_W      = $clog2(MAX_PENDING + 1);

   // Request action codes.
   localparam logic [1:0] ACT_DECIMAL = 2'd0;
   localparam logic [1:0] ACT_HEX     = 2'd1;
   localparam logic [1:0] ACT_GLYPH   = 2'd2;
   localparam logic [1:0] ACT_BLANK   = 2'd3;

   typedef enum logic [1:0] {
      MODE_DEC,
      MODE_HEX,
      MODE_GLYPH,
      MODE_BLANK
   } mode_type;

   typedef logic [SEL_POSITIONS-1:0][GLYPH_W-1:0] glyph_vec_type;

   // Classified request as it travels through the queue.
   typedef struct packed {
      mode_type            mode;
      logic [VALUE_W-1:0]  num;
      glyph_vec_type       glyphs;
      logic [IDX_W-1:0]    last_idx;
   } cmd_type;

   typedef struct packed {
      logic not_full;
      logic not_empty;
   } q_stat_type;

   // Active-low segment pattern of a hex digit.
   function automatic logic [7:0] digit_seg(input logic [3:0] d);
      logic [7:0] seg;
      case (d)
         4'h0:    seg = 8'hc0;
         4'h1:    seg = 8'hf9;
         4'h2:    seg = 8'ha4;
         4'h3:    seg = 8'hb0;
         4'h4:    seg = 8'h99;
         4'h5:    seg = 8'h92;
         4'h6:    seg = 8'h82;
         4'h7:    seg = 8'hf8;
         4'h8:    seg = 8'h80;
         4'h9:    seg = 8'h90;
         4'ha:    seg = 8'h88;
         4'hb:    seg = 8'h83;
         4'hc:    seg = 8'hc6;
         4'hd:    seg = 8'ha1;
         4'he:    seg = 8'h86;
         default: seg = 8'h8e;
      endcase
      return seg;
   endfunction

   // Segment pattern of a traffic-light glyph; codes above four show a dark digit.
   function automatic logic [7:0] glyph_seg(input logic [GLYPH_W-1:0] g);
      logic [7:0] seg;
      case (g)
         3'd0:    seg = 8'hff - 8'd80;
         3'd1:    seg = 8'd64 + 8'd128;
         3'd2:    seg = 8'd130;
         3'd3:    seg = 8'h99;
         3'd4:    seg = 8'hff - 8'd64;
         default: seg = 8'hFF;
      endcase
      return seg;
   endfunction

   // Digit-select byte: upper nibble high, one bit for the position.
   function automatic logic [7:0] sel_byte(input logic [SEL_W-1:0] pos);
      logic [7:0] sel;
      sel = 8'hF0;
      sel[pos] = 1'b1;
      return sel;
   endfunction

endpackage

@@ design/ssd_req_if.sv @@
// Request channel: valid/ready handshake carrying one display request.
interface ssd_req_if;
   logic                                valid;
   logic                                ready;
   logic [1:0]                          action;
   logic [ssd_pkg::VALUE_W-1:0]         value;
   logic [ssd_pkg::GLYPH_W-1:0]         glyph_a;
   logic [ssd_pkg::GLYPH_W-1:0]         glyph_b;
   logic [ssd_pkg::GLYPH_W-1:0]         glyph_c;
   logic [ssd_pkg::GLYPH_W-1:0]         glyph_d;

   modport source (output valid, action, value, glyph_a, glyph_b, glyph_c, glyph_d,
                   input ready);
   modport sink   (input valid, action, value, glyph_a, glyph_b, glyph_c, glyph_d,
                   output ready);
endinterface

@@ design/ssd_rsp_if.sv @@
// Response channel: valid/ready handshake carrying one display frame.
interface ssd_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [ssd_pkg::FRAME_W-1:0]         frame_bits;
   logic [ssd_pkg::FWID_W-1:0]          frame_width;
   logic                                last;

   modport source (output valid, frame_bits, frame_width, last, input ready);
   modport sink   (input valid, frame_bits, frame_width, last, output ready);
endinterface

@@ design/seven_segment_serial_display_driver.sv @@
// Top level of the seven-segment serial display driver.
//
// Each request item on req_chan turns into a burst of frame items on rsp_chan for a
// four-digit shift-register display. A decimal or hex request gives one 16-bit frame
// per digit (segment byte high, select byte low, units digit on the last select
// position) and then an 8-bit zero trailer frame: five items. A glyph request gives
// four 16-bit frames, positions 0 to 3, and a blank request one all-ones frame. The
// last flag marks the final frame of each request. Frames leave at one per cycle
// while the consumer takes them; the result channel's single frame per cycle sets
// this rate. The front part classifies a request in the cycle it is accepted and
// writes it into a two-entry command queue; requests are taken whenever the queue
// has room. The back part loads the next command in the same cycle that it issues
// the final frame of the current one, so bursts follow each other without a gap.
// A request accepted into an empty block passes through the queue entry and the
// back part's command registers before its first frame reaches the output register.
// Frames sit in an output register that holds its item while the consumer stalls;
// the back part then waits, and the queue keeps taking requests until it is full.
module seven_segment_serial_display_driver (
   input  logic          clock,
   input  logic          reset,
   ssd_req_if.sink       req_chan,
   ssd_rsp_if.source     rsp_chan
);

   logic                  push_valid;
   ssd_pkg::cmd_type      push_cmd;
   ssd_pkg::cmd_type      pop_cmd;
   ssd_pkg::q_stat_type   q_stat;
   logic                  pop;

   // Decode the action into a mode and the number of frames it needs.
   ssd_front u_front (
      .req_chan   (req_chan),
      .q_stat     (q_stat),
      .push_valid (push_valid),
      .push_cmd   (push_cmd)
   );

   // The queue lets the input side keep accepting while a burst is still going out.
   ssd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_cmd   (push_cmd),
      .pop        (pop),
      .pop_cmd    (pop_cmd),
      .q_stat     (q_stat)
   );

   // Frame sequencer: digit extraction, segment lookup and the output register.
   ssd_back u_back (
      .clock    (clock),
      .reset    (reset),
      .pop_cmd  (pop_cmd),
      .q_stat   (q_stat),
      .pop      (pop),
      .rsp_chan (rsp_chan)
   );

endmodule

@@ design/ssd_front.sv @@
// Front part: accepts requests and classifies them into queue commands.
module ssd_front (
   ssd_req_if.sink               req_chan,
   input  ssd_pkg::q_stat_type   q_stat,
   output logic                  push_valid,
   output ssd_pkg::cmd_type      push_cmd
);

   assign req_chan.ready = q_stat.not_full;
   assign push_valid     = req_chan.valid && q_stat.not_full;

   always_comb begin
      push_cmd.num       = req_chan.value;
      push_cmd.glyphs[0] = req_chan.glyph_a;
      push_cmd.glyphs[1] = req_chan.glyph_b;
      push_cmd.glyphs[2] = req_chan.glyph_c;
      push_cmd.glyphs[3] = req_chan.glyph_d;
      case (req_chan.action)
         ssd_pkg::ACT_DECIMAL: begin
            push_cmd.mode     = ssd_pkg::MODE_DEC;
            push_cmd.last_idx = ssd_pkg::IDX_W'(ssd_pkg::DIGITS_USED);
         end
         ssd_pkg::ACT_HEX: begin
            push_cmd.mode     = ssd_pkg::MODE_HEX;
            push_cmd.last_idx = ssd_pkg::IDX_W'(ssd_pkg::DIGITS_USED);
         end
         ssd_pkg::ACT_GLYPH: begin
            push_cmd.mode     = ssd_pkg::MODE_GLYPH;
            push_cmd.last_idx = ssd_pkg::IDX_W'(ssd_pkg::DIGITS_USED - 1);
         end
         default: begin
            push_cmd.mode     = ssd_pkg::MODE_BLANK;
            push_cmd.last_idx = '0;
         end
      endcase
   end

endmodule

@@ design/ssd_queue.sv @@
// Short command queue that decouples the front and back parts.
module ssd_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push_valid,
   input  ssd_pkg::cmd_type      push_cmd,
   input  logic                  pop,
   output ssd_pkg::cmd_type      pop_cmd,
   output ssd_pkg::q_stat_type   q_stat
);

   ssd_pkg::cmd_type                  entries_ff [ssd_pkg::QUEUE_DEPTH];
   logic [ssd_pkg::QPTR_W-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [ssd_pkg::QPTR_W-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [ssd_pkg::QCNT_W-1:0]        count_ff, count_in;
   logic                              do_push, do_pop;

   localparam logic [ssd_pkg::QPTR_W-1:0] PTR_LAST = ssd_pkg::QPTR_W'(ssd_pkg::QUEUE_DEPTH - 1);
   localparam logic [ssd_pkg::QCNT_W-1:0] CNT_FULL = ssd_pkg::QCNT_W'(ssd_pkg::QUEUE_DEPTH);

   always_comb begin
      q_stat.not_full  = (count_ff != CNT_FULL);
      q_stat.not_empty = (count_ff != '0);
      do_push = push_valid && q_stat.not_full;
      do_pop  = pop && q_stat.not_empty;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   assign pop_cmd = entries_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

@@ design/ssd_back.sv @@
// Back part: steps through a command and emits one frame per cycle while the output register is free.
module ssd_back (
   input  logic                  clock,
   input  logic                  reset,
   input  ssd_pkg::cmd_type      pop_cmd,
   input  ssd_pkg::q_stat_type   q_stat,
   output logic                  pop,
   ssd_rsp_if.source             rsp_chan
);

   localparam logic [ssd_pkg::IDX_W-1:0] LAST_POS = ssd_pkg::IDX_W'(ssd_pkg::DIGITS_USED - 1);

   logic                               active_ff, active_in;
   ssd_pkg::mode_type                  mode_ff, mode_in;
   logic [ssd_pkg::VALUE_W-1:0]        num_ff, num_in;
   ssd_pkg::glyph_vec_type             glyphs_ff, glyphs_in;
   logic [ssd_pkg::IDX_W-1:0]          idx_ff, idx_in;
   logic [ssd_pkg::IDX_W-1:0]          last_idx_ff, last_idx_in;

   logic                               rsp_valid_ff, rsp_valid_in;
   logic [ssd_pkg::FRAME_W-1:0]        bits_ff, bits_in;
   logic [ssd_pkg::FWID_W-1:0]         width_ff, width_in;
   logic                               last_ff, last_in;

   logic                               out_free, emit, at_end, load;
   logic [2*ssd_pkg::VALUE_W-1:0]      prod;
   logic [ssd_pkg::VALUE_W-1:0]        quot, diff;
   logic [3:0]                         digit;
   logic [ssd_pkg::SEL_W-1:0]          pos;
   logic [ssd_pkg::FRAME_W-1:0]        frame;
   logic [ssd_pkg::FWID_W-1:0]         frame_width;

   always_comb begin
      // One reciprocal multiply per frame gives the next decimal digit.
      prod  = {{ssd_pkg::VALUE_W{1'b0}}, num_ff} * {{ssd_pkg::VALUE_W{1'b0}}, ssd_pkg::DIV10_MUL};
      quot  = ssd_pkg::VALUE_W'(prod >> ssd_pkg::DIV10_SHIFT);
      diff  = num_ff - ((quot << 3) + (quot << 1));
      digit = (mode_ff == ssd_pkg::MODE_DEC) ? diff[3:0] : num_ff[3:0];
      pos   = (mode_ff == ssd_pkg::MODE_GLYPH) ? ssd_pkg::SEL_W'(idx_ff)
                                               : ssd_pkg::SEL_W'(LAST_POS - idx_ff);
      at_end = (idx_ff == last_idx_ff);

      frame_width = ssd_pkg::WIDTH_FULL;
      case (mode_ff)
         ssd_pkg::MODE_BLANK: begin
            frame = '1;
         end
         ssd_pkg::MODE_GLYPH: begin
            frame = {ssd_pkg::glyph_seg(glyphs_ff[0]), ssd_pkg::sel_byte(pos)};
         end
         default: begin
            if (at_end) begin
               frame       = '0;
               frame_width = ssd_pkg::WIDTH_SHORT;
            end else begin
               frame = {ssd_pkg::digit_seg(digit), ssd_pkg::sel_byte(pos)};
            end
         end
      endcase

      out_free = !rsp_valid_ff || rsp_chan.ready;
      emit     = active_ff && out_free;
      load     = q_stat.not_empty && (!active_ff || (emit && at_end));
      pop      = load;

      active_in   = active_ff;
      mode_in     = mode_ff;
      num_in      = num_ff;
      glyphs_in   = glyphs_ff;
      idx_in      = idx_ff;
      last_idx_in = last_idx_ff;
      if (emit) begin
         num_in    = (mode_ff == ssd_pkg::MODE_DEC) ? quot : (num_ff >> 4);
         glyphs_in = glyphs_ff >> ssd_pkg::GLYPH_W;
         idx_in    = idx_ff + 1'b1;
         if (at_end) begin
            active_in = 1'b0;
         end
      end
      if (load) begin
         active_in   = 1'b1;
         mode_in     = pop_cmd.mode;
         num_in      = pop_cmd.num;
         glyphs_in   = pop_cmd.glyphs;
         idx_in      = '0;
         last_idx_in = pop_cmd.last_idx;
      end

      rsp_valid_in = emit ? 1'b1 : (rsp_chan.ready ? 1'b0 : rsp_valid_ff);
      bits_in      = emit ? frame : bits_ff;
      width_in     = emit ? frame_width : width_ff;
      last_in      = emit ? at_end : last_ff;
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.frame_bits  = bits_ff;
   assign rsp_chan.frame_width = width_ff;
   assign rsp_chan.last        = last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else begin
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
         idx_ff       <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff     <= mode_in;
      num_ff      <= num_in;
      glyphs_ff   <= glyphs_in;
      last_idx_ff <= last_idx_in;
      bits_ff     <= bits_in;
      width_ff    <= width_in;
      last_ff     <= last_in;
   end

endmodule

@@ design/ssd_checker.sv @@
// Port-level checker for the seven-segment serial display driver, with its bind.
`include "assert_macros.svh"

module ssd_checker (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic                         req_ready,
   input  logic                         rsp_valid,
   input  logic                         rsp_ready,
   input  logic [ssd_pkg::FRAME_W-1:0]  rsp_frame_bits,
   input  logic [ssd_pkg::FWID_W-1:0]   rsp_frame_width,
   input  logic                         rsp_last
);

   // Requests accepted whose final frame has not been taken yet.
   logic [ssd_pkg::PEND_W-1:0] pending_ff, pending_in;
   logic                       req_take, done_take;

   localparam logic [ssd_pkg::PEND_W-1:0] PEND_MAX = ssd_pkg::PEND_W'(ssd_pkg::MAX_PENDING);

   always_comb begin
      req_take   = req_valid && req_ready;
      done_take  = rsp_valid && rsp_ready && rsp_last;
      pending_in = pending_ff;
      if (req_take && !done_take) begin
         pending_in = pending_ff + 1'b1;
      end else if (done_take && !req_take) begin
         pending_in = pending_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   `ASSERT_CLK(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_frame_bits) && $stable(rsp_frame_width) && $stable(rsp_last), "stalled frame changed")
   `ASSERT_CLK_ALWAYS(a_rsp_reset, clock, reset |=> !rsp_valid, "frame shown right after reset")
   `ASSERT_CLK(a_no_orphan, clock, reset, rsp_valid |-> pending_ff != '0, "frame without an open request")
   `ASSERT_CLK(a_full_stall, clock, reset, pending_ff == PEND_MAX |-> !req_ready, "request taken beyond capacity")

endmodule

bind seven_segment_serial_display_driver ssd_checker u_ssd_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_chan.valid),
   .req_ready       (req_chan.ready),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_frame_bits  (rsp_chan.frame_bits),
   .rsp_frame_width (rsp_chan.frame_width),
   .rsp_last        (rsp_chan.last)
);

@@ tb/ssd_frame_checker.sv @@
// Frame checker: expands each accepted display request into the frames it owes
// and compares them with the frames that leave the driver.
module ssd_frame_checker (
   input  logic clock,
   input  logic reset,
   ssd_req_if   req_mon,
   ssd_rsp_if   rsp_mon,
   output int   mismatch_count,
   output int   frames_owed
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [ssd_pkg::FRAME_W-1:0] bits;
      logic [ssd_pkg::FWID_W-1:0]  width;
      logic                        last;
   } display_frame_type;

   // Active-low segment patterns for hex digits 0..F and for glyph codes 0..7.
   localparam logic [7:0] DIGIT_SEGMENTS [16] = '{
      8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99, 8'h92, 8'h82, 8'hF8,
      8'h80, 8'h90, 8'h88, 8'h83, 8'hC6, 8'hA1, 8'h86, 8'h8E
   };
   localparam logic [7:0] GLYPH_SEGMENTS [8] = '{
      8'hAF, 8'hC0, 8'h82, 8'h99, 8'hBF, 8'hFF, 8'hFF, 8'hFF
   };

   display_frame_type owed_frames [$];

   function automatic logic [7:0] position_select(input int unsigned pos);
      return 8'hF0 | (8'd1 << (pos % ssd_pkg::SEL_POSITIONS));
   endfunction

   function automatic void owe_frame(input logic [ssd_pkg::FRAME_W-1:0] bits,
                                     input logic [ssd_pkg::FWID_W-1:0] width,
                                     input logic last);
      display_frame_type f;
      f.bits  = bits;
      f.width = width;
      f.last  = last;
      owed_frames.push_back(f);
   endfunction

   // Works out the frames that one request produces.
   function automatic void frames_of_request(input logic [1:0] act,
                                             input logic [ssd_pkg::VALUE_W-1:0] val,
                                             input ssd_pkg::glyph_vec_type glyphs);
      int unsigned num;
      int unsigned base;
      int unsigned d;
      num = val;
      case (act)
         ssd_pkg::ACT_BLANK: begin
            owe_frame(16'hFFFF, ssd_pkg::WIDTH_FULL, 1'b1);
         end
         ssd_pkg::ACT_GLYPH: begin
            for (int p = 0; p < ssd_pkg::DIGITS_USED; p++) begin
               owe_frame({GLYPH_SEGMENTS[glyphs[p]], position_select(p)},
                         ssd_pkg::WIDTH_FULL, p == ssd_pkg::DIGITS_USED - 1);
            end
         end
         default: begin
            base = (act == ssd_pkg::ACT_DECIMAL) ? 10 : 16;
            // Units digit goes to the last select position.
            for (int i = 0; i < ssd_pkg::DIGITS_USED; i++) begin
               d = num % base;
               owe_frame({DIGIT_SEGMENTS[d[3:0]],
                          position_select(ssd_pkg::DIGITS_USED - 1 - i)},
                         ssd_pkg::WIDTH_FULL, 1'b0);
               num = num / base;
            end
            owe_frame(16'h0000, ssd_pkg::WIDTH_SHORT, 1'b1);
         end
      endcase
   endfunction

   initial begin
      mismatch_count = 0;
      frames_owed    = 0;
   end

   always @(posedge clock) begin
      display_frame_type      want;
      ssd_pkg::glyph_vec_type g;
      if (!reset) begin
         if (req_mon.valid && req_mon.ready) begin
            g[0] = req_mon.glyph_a;
            g[1] = req_mon.glyph_b;
            g[2] = req_mon.glyph_c;
            g[3] = req_mon.glyph_d;
            frames_of_request(req_mon.action, req_mon.value, g);
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (owed_frames.size() == 0) begin
               mismatch_count++;
               $display("%0t: unexpected frame bits=%h width=%0d last=%b", $realtime,
                        rsp_mon.frame_bits, rsp_mon.frame_width, rsp_mon.last);
            end else begin
               want = owed_frames.pop_front();
               if (rsp_mon.frame_bits !== want.bits) begin
                  mismatch_count++;
                  $display("%0t: frame_bits expected %h actual %h", $realtime,
                           want.bits, rsp_mon.frame_bits);
               end
               if (rsp_mon.frame_width !== want.width) begin
                  mismatch_count++;
                  $display("%0t: frame_width expected %0d actual %0d", $realtime,
                           want.width, rsp_mon.frame_width);
               end
               if (rsp_mon.last !== want.last) begin
                  mismatch_count++;
                  $display("%0t: last expected %b actual %b", $realtime,
                           want.last, rsp_mon.last);
               end
            end
         end
         frames_owed = owed_frames.size();
      end
   end

endmodule

@@ tb/seven_segment_serial_display_driver_tb.sv @@
// Top level of the display driver testbench: clock, reset, request and consumer stimulus.
module seven_segment_serial_display_driver_tb;
   timeunit 1ns;
   timeprecision 1ps;

   // Cycles without any accepted item before the run is declared hung. The
   // longest correct quiet stretch is the consumer hold-off below, so this sits
   // well above it.
   localparam int WATCHDOG_LIMIT = 2000;
   // Length of the one long consumer hold-off that fills the command queue.
   localparam int HOLD_OFF_CYCLES = 300;
   // Cycles allowed after the last owed frame for any stray frame to show up.
   localparam int DRAIN_CYCLES = 12;
   localparam int RANDOM_ITEMS = 88;

   logic clock;
   logic reset;
   int   mismatch_count;
   int   frames_owed;
   int   idle_cycles;
   int   burst_left;
   logic pressure_due;

   ssd_req_if req_chan ();
   ssd_rsp_if rsp_chan ();

   seven_segment_serial_display_driver dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   ssd_frame_checker checker_inst (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_chan),
      .rsp_mon        (rsp_chan),
      .mismatch_count (mismatch_count),
      .frames_owed    (frames_owed)
   );

   initial clock = 1'b0;
   always #10 clock = ~clock;

   // The watchdog restarts on every accepted item on either channel. A hung
   // driver, or one that stops producing owed frames, trips it.
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Consumer side. The ready pattern switches in turn between always ready,
   // random stalls and a fixed periodic stall, so stalls fall on
   // every frame of a burst. Once during the random part it holds off for a long
   // stretch while requests keep coming; the driver must fill its queue, drop
   // req ready and then drain without losing or reordering any frame.
   initial begin : consumer
      int unsigned tick;
      logic        held;
      tick = 0;
      held = 1'b0;
      rsp_chan.ready = 1'b0;
      wait (reset === 1'b0);
      forever begin
         @(negedge clock);
         if (pressure_due && !held) begin
            rsp_chan.ready = 1'b0;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
            held = 1'b1;
         end
         case ((tick / 64) % 3)
            0:       rsp_chan.ready = 1'b1;
            1:       rsp_chan.ready = ($urandom_range(0, 99) < 60);
            default: rsp_chan.ready = ((tick % 5) != 3);
         endcase
         tick++;
      end
   end

   // Offers one request at the current falling edge and returns at the falling
   // edge after it is accepted, with valid still high.
   task automatic offer_request(input logic [1:0] act,
                                input logic [ssd_pkg::VALUE_W-1:0] val,
                                input logic [ssd_pkg::GLYPH_W-1:0] ga,
                                input logic [ssd_pkg::GLYPH_W-1:0] gb,
                                input logic [ssd_pkg::GLYPH_W-1:0] gc,
                                input logic [ssd_pkg::GLYPH_W-1:0] gd);
      req_chan.valid   = 1'b1;
      req_chan.action  = act;
      req_chan.value   = val;
      req_chan.glyph_a = ga;
      req_chan.glyph_b = gb;
      req_chan.glyph_c = gc;
      req_chan.glyph_d = gd;
      do begin
         @(posedge clock);
      end while (!req_chan.ready);
      @(negedge clock);
   endtask

   // Sender pacing: bursts of random length, separated by random gaps. Some
   // bursts are long so that stretches with no idling occur as well.
   task automatic pace_sender();
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_chan.valid = 1'b0;
         repeat ($urandom_range(1, 7)) @(negedge clock);
         burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(15, 30)
                                                   : $urandom_range(0, 6);
      end
   endtask

   initial begin : stimulus
      logic [1:0]                  act;
      logic [ssd_pkg::VALUE_W-1:0] val;
      reset          = 1'b1;
      pressure_due   = 1'b0;
      burst_left     = 3;
      idle_cycles    = 0;
      req_chan.valid   = 1'b0;
      req_chan.action  = ssd_pkg::ACT_DECIMAL;
      req_chan.value   = '0;
      req_chan.glyph_a = '0;
      req_chan.glyph_b = '0;
      req_chan.glyph_c = '0;
      req_chan.glyph_d = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part. Decimal covers zero, one and two digits, a full display,
      // the first value with a dropped digit and the largest value. Hex covers every
      // nibble value. Glyph mode covers each code including the dark codes five to
      // seven. Unused fields carry junk so that ignoring them is checked too.
      offer_request(ssd_pkg::ACT_DECIMAL, 16'd0,     3'd7, 3'd7, 3'd7, 3'd7); pace_sender();
      offer_request(ssd_pkg::ACT_DECIMAL, 16'd9,     3'd0, 3'd0, 3'd0, 3'd0); pace_sender();
      offer_request(ssd_pkg::ACT_DECIMAL, 16'd10,    3'd5, 3'd2, 3'd6, 3'd1); pace_sender();
      offer_request(ssd_pkg::ACT_DECIMAL, 16'd1234,  3'd0, 3'd0, 3'd0, 3'd0); pace_sender();
      offer_request(ssd_pkg::ACT_DECIMAL, 16'd9999,  3'd0, 3'd0, 3'd0, 3'd0); pace_sender();
      offer_request(ssd_pkg::ACT_DECIMAL, 16'd10000, 3'd0, 3'd0, 3'd0, 3'd0); pace_sender();
      offer_request(ssd_pkg::ACT_DECIMAL, 16'd65535, 3'd7, 3'd7, 3'd7, 3'd7); pace_sender();
      offer_request(ssd_pkg::ACT_DECIMAL, 16'h5555,  3'd0, 3'd0, 3'd0, 3'd0); pace_sender();
      offer_request(ssd_pkg::ACT_HEX,     16'h0000,  3'd7, 3'd7, 3'd7, 3'd7); pace_sender();
      offer_request(ssd_pkg::ACT_HEX,     16'h0123,  3'd0, 3'd0, 3'd0, 3'd0); pace_sender();
      offer_request(ssd_pkg::ACT_HEX,     16'h4567,  3'd0, 3'd0, 3'd0, 3'd0); pace_sender();
      offer_request(ssd_pkg::ACT_HEX,     16'h89AB,  3'd0, 3'd0, 3'd0, 3'd0); pace_sender();
      offer_request(ssd_pkg::ACT_HEX,     16'hCDEF,  3'd0, 3'd0, 3'd0, 3'd0); pace_sender();
      offer_request(ssd_pkg::ACT_HEX,     16'hFFFF,  3'd0, 3'd0, 3'd0, 3'd0); pace_sender();
      offer_request(ssd_pkg::ACT_HEX,     16'hAAAA,  3'd0, 3'd0, 3'd0, 3'd0); pace_sender();
      offer_request(ssd_pkg::ACT_GLYPH,   16'hFFFF,  3'd0, 3'd1, 3'd2, 3'd3); pace_sender();
      offer_request(ssd_pkg::ACT_GLYPH,   16'h0000,  3'd4, 3'd5, 3'd6, 3'd7); pace_sender();
      offer_request(ssd_pkg::ACT_GLYPH,   16'h1234,  3'd3, 3'd0, 3'd4, 3'd1); pace_sender();
      offer_request(ssd_pkg::ACT_GLYPH,   16'h0000,  3'd7, 3'd7, 3'd7, 3'd7); pace_sender();
      offer_request(ssd_pkg::ACT_BLANK,   16'hFFFF,  3'd7, 3'd7, 3'd7, 3'd7); pace_sender();
      offer_request(ssd_pkg::ACT_BLANK,   16'h0000,  3'd0, 3'd0, 3'd0, 3'd0); pace_sender();
      offer_request(ssd_pkg::ACT_BLANK,   16'h8001,  3'd2, 3'd4, 3'd6, 3'd1); pace_sender();

      // Random part. Values lean partly on short numbers and decimal
      // boundaries so that leading zeros and digit carries show up often;
      // glyph codes are mostly the real glyphs with some dark ones mixed in.
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == 20) begin
            pressure_due = 1'b1;
         end
         act = $urandom_range(0, 3);
         case ($urandom_range(0, 3))
            0:       val = $urandom_range(0, 99);
            1:       val = 16'd9990 + $urandom_range(0, 20);
            default: val = $urandom_range(0, 65535);
         endcase
         offer_request(act, val,
                       ($urandom_range(0, 4) == 0) ? $urandom_range(5, 7) : $urandom_range(0, 4),
                       ($urandom_range(0, 4) == 0) ? $urandom_range(5, 7) : $urandom_range(0, 4),
                       ($urandom_range(0, 4) == 0) ? $urandom_range(5, 7) : $urandom_range(0, 4),
                       ($urandom_range(0, 4) == 0) ? $urandom_range(5, 7) : $urandom_range(0, 4));
         pace_sender();
      end
      req_chan.valid = 1'b0;

      // Wait for every owed frame, then a few more cycles so that any extra
      // frame from the driver is caught. The watchdog covers a stuck drain.
      wait (frames_owed == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && frames_owed == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
